// File: design/assert_macros.svh
// assertion macros used by the checker file sfcm_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clock edge outside reset
`define SFCM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property that must also hold while reset is applied
`define SFCM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/sfcm_pkg.sv
// shared types and constants for the float compare mask pipeline
// no dependencies
`timescale 1ns / 1ps

package sfcm_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned LaneWidth = 32;
    localparam int unsigned PredWidth = 5;

    // low four predicate bits, published relation encoding
    typedef enum logic [3:0] {
        REL_EQ_O   = 4'd0,
        REL_LT_O   = 4'd1,
        REL_LE_O   = 4'd2,
        REL_UNORD  = 4'd3,
        REL_NEQ_U  = 4'd4,
        REL_NLT_U  = 4'd5,
        REL_NLE_U  = 4'd6,
        REL_ORD    = 4'd7,
        REL_EQ_U   = 4'd8,
        REL_NGE_U  = 4'd9,
        REL_NGT_U  = 4'd10,
        REL_FALSE  = 4'd11,
        REL_NEQ_O  = 4'd12,
        REL_GE_O   = 4'd13,
        REL_GT_O   = 4'd14,
        REL_TRUE   = 4'd15
    } rel_t;

    // result kind chosen by the mode bits
    typedef enum logic [1:0] {
        OUT_ZERO   = 2'd0,
        OUT_COPY_A = 2'd1,
        OUT_DOUBLE = 2'd2,
        OUT_SINGLE = 2'd3
    } out_kind_t;

    // per-lane flags after the compare
    typedef struct packed {
        logic un;
        logic eq;
        logic lt;
    } cmp_flags_t;

    typedef struct packed {
        rel_t      rel;
        out_kind_t kind;
        logic      scalar;
    } ctl_t;

    // map to sortable key; both zeros share the key of +0
    function automatic logic [DataWidth-1:0] order_key64(input logic [DataWidth-1:0] v);
        logic [DataWidth-1:0] z;
        z = (v[DataWidth-2:0] == '0) ? '0 : v;
        order_key64 = z[DataWidth-1] ? ~z : (z | {1'b1, {(DataWidth-1){1'b0}}});
    endfunction

    function automatic logic [LaneWidth-1:0] order_key32(input logic [LaneWidth-1:0] v);
        logic [LaneWidth-1:0] z;
        z = (v[LaneWidth-2:0] == '0) ? '0 : v;
        order_key32 = z[LaneWidth-1] ? ~z : (z | {1'b1, {(LaneWidth-1){1'b0}}});
    endfunction

    function automatic logic rel_eval(input rel_t rel, input cmp_flags_t f);
        logic gt;
        logic r;
        gt = !f.un && !f.eq && !f.lt;
        case (rel)
            REL_EQ_O:  r = f.eq;
            REL_LT_O:  r = f.lt;
            REL_LE_O:  r = f.lt || f.eq;
            REL_UNORD: r = f.un;
            REL_NEQ_U: r = f.un || !f.eq;
            REL_NLT_U: r = f.un || gt || f.eq;
            REL_NLE_U: r = f.un || gt;
            REL_ORD:   r = !f.un;
            REL_EQ_U:  r = f.un || f.eq;
            REL_NGE_U: r = f.un || f.lt;
            REL_NGT_U: r = f.un || f.lt || f.eq;
            REL_FALSE: r = 1'b0;
            REL_NEQ_O: r = !f.un && !f.eq;
            REL_GE_O:  r = gt || f.eq;
            REL_GT_O:  r = gt;
            REL_TRUE:  r = 1'b1;
            default:   r = 1'b0;
        endcase
        rel_eval = r;
    endfunction

endpackage

// File: design/sfcm_pipe_ctl.sv
// shared valid/advance control for the elastic pipeline
// depends on sfcm_pkg
`timescale 1ns / 1ps

module sfcm_pipe_ctl
    import sfcm_pkg::*;
#(
    parameter int unsigned Stages = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_stall,
    output logic [Stages-1:0] stage_valid,
    output logic [Stages-1:0] stage_load,
    output logic              in_stall
);

    logic [Stages-1:0] valid_reg;
    logic [Stages-1:0] valid_next;
    logic [Stages:0]   open;

    // a stage can take a beat when it is empty or its beat moves on
    always_comb
    begin
        open[Stages] = !out_stall;
        for (int i = Stages - 1; i >= 0; i--)
        begin
            open[i] = !valid_reg[i] || open[i+1];
        end
        for (int i = 0; i < Stages; i++)
        begin
            stage_load[i] = open[i];
            if (open[i])
            begin
                valid_next[i] = (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i-1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign stage_valid = valid_reg;
    assign in_stall    = !open[0];

endmodule

// File: design/simd_float_compare_mask.sv
// float compare mask: an accepted beat moves through the stage 1, stage 2 and stage 3 registers to the output
// throughput one beat per cycle while the output is not stalled; a stall holds only the beats that cannot move on
// stage 1 decodes and forms sortable keys, stage 2 compares, stage 3 builds the mask
// reset clears only the valid bits; payload registers are not reset
// depends on sfcm_pkg and sfcm_pipe_ctl
`timescale 1ns / 1ps

module simd_float_compare_mask
    import sfcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [DataWidth-1:0] a_bits,
    input  logic [DataWidth-1:0] b_bits,
    input  logic [PredWidth-1:0] predicate,
    input  logic                 dbl_mode,
    input  logic                 scalar_mode,
    input  logic                 is_lowest_chunk,
    input  logic                 clear_result,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DataWidth-1:0] mask_bits
);

    localparam int unsigned Stages = 3;

    logic [Stages-1:0] stage_valid;
    logic [Stages-1:0] stage_load;

    sfcm_pipe_ctl #(.Stages(Stages)) u_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .out_stall   (out_stall),
        .stage_valid (stage_valid),
        .stage_load  (stage_load),
        .in_stall    (in_stall)
    );

    // stage 1: keys and nan flags
    ctl_t                 s1_ctl_reg, s1_ctl_next;
    logic [DataWidth-1:0] s1_a_reg;
    logic [DataWidth-1:0] s1_ka_reg, s1_kb_reg, s1_ka_next, s1_kb_next;
    logic [1:0]           s1_un_reg, s1_un_next;

    always_comb
    begin
        s1_ctl_next.rel    = rel_t'(predicate[3:0]);
        s1_ctl_next.scalar = scalar_mode;
        if (clear_result)
        begin
            s1_ctl_next.kind = OUT_ZERO;
        end
        else if (scalar_mode && !is_lowest_chunk)
        begin
            s1_ctl_next.kind = OUT_COPY_A;
        end
        else if (dbl_mode)
        begin
            s1_ctl_next.kind = OUT_DOUBLE;
        end
        else
        begin
            s1_ctl_next.kind = OUT_SINGLE;
        end
        if (dbl_mode)
        begin
            s1_ka_next = order_key64(a_bits);
            s1_kb_next = order_key64(b_bits);
            s1_un_next[0] = (a_bits[62:0] > 63'h7FF0000000000000)
                         || (b_bits[62:0] > 63'h7FF0000000000000);
            s1_un_next[1] = 1'b0;
        end
        else
        begin
            s1_ka_next = {order_key32(a_bits[63:32]), order_key32(a_bits[31:0])};
            s1_kb_next = {order_key32(b_bits[63:32]), order_key32(b_bits[31:0])};
            s1_un_next[0] = (a_bits[30:0] > 31'h7F800000) || (b_bits[30:0] > 31'h7F800000);
            s1_un_next[1] = (a_bits[62:32] > 31'h7F800000) || (b_bits[62:32] > 31'h7F800000);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            s1_ctl_reg <= s1_ctl_next;
            s1_a_reg   <= a_bits;
            s1_ka_reg  <= s1_ka_next;
            s1_kb_reg  <= s1_kb_next;
            s1_un_reg  <= s1_un_next;
        end
    end

    // stage 2: key compares
    ctl_t                 s2_ctl_reg;
    logic [DataWidth-1:0] s2_a_reg;
    cmp_flags_t           s2_f_reg [2];
    cmp_flags_t           s2_f_next [2];

    always_comb
    begin
        if (s1_ctl_reg.kind == OUT_DOUBLE)
        begin
            s2_f_next[0].un = s1_un_reg[0];
            s2_f_next[0].eq = !s1_un_reg[0] && (s1_ka_reg == s1_kb_reg);
            s2_f_next[0].lt = !s1_un_reg[0] && (s1_ka_reg < s1_kb_reg);
        end
        else
        begin
            s2_f_next[0].un = s1_un_reg[0];
            s2_f_next[0].eq = !s1_un_reg[0] && (s1_ka_reg[31:0] == s1_kb_reg[31:0]);
            s2_f_next[0].lt = !s1_un_reg[0] && (s1_ka_reg[31:0] < s1_kb_reg[31:0]);
        end
        s2_f_next[1].un = s1_un_reg[1];
        s2_f_next[1].eq = !s1_un_reg[1] && (s1_ka_reg[63:32] == s1_kb_reg[63:32]);
        s2_f_next[1].lt = !s1_un_reg[1] && (s1_ka_reg[63:32] < s1_kb_reg[63:32]);
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[1])
        begin
            s2_ctl_reg  <= s1_ctl_reg;
            s2_a_reg    <= s1_a_reg;
            s2_f_reg[0] <= s2_f_next[0];
            s2_f_reg[1] <= s2_f_next[1];
        end
    end

    // stage 3: predicate and mask assembly
    logic [DataWidth-1:0] mask_reg, mask_next;
    logic                 hit_lo, hit_hi;

    always_comb
    begin
        hit_lo = rel_eval(s2_ctl_reg.rel, s2_f_reg[0]);
        hit_hi = rel_eval(s2_ctl_reg.rel, s2_f_reg[1]);
        case (s2_ctl_reg.kind)
            OUT_ZERO:   mask_next = '0;
            OUT_COPY_A: mask_next = s2_a_reg;
            OUT_DOUBLE: mask_next = {DataWidth{hit_lo}};
            OUT_SINGLE:
            begin
                mask_next[31:0]  = {LaneWidth{hit_lo}};
                mask_next[63:32] = s2_ctl_reg.scalar ? s2_a_reg[63:32] : {LaneWidth{hit_hi}};
            end
            default:    mask_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[2])
        begin
            mask_reg <= mask_next;
        end
    end

    assign out_valid = stage_valid[Stages-1];
    assign mask_bits = mask_reg;

endmodule

// File: design/sfcm_checker.sv
// port-level checks for the float compare mask block
// depends on sfcm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfcm_checker
    import sfcm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [DataWidth-1:0] mask_bits
);

    `SFCM_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(mask_bits), "stalled output beat changed")
    `SFCM_ASSERT(a_no_stall_free, clk, rst_n, !out_stall |-> !in_stall, "input stalled while output side is free")
    `SFCM_ASSERT(a_flow, clk, rst_n, in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "accepted beat did not arrive in three cycles")
    `SFCM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n && $past(!rst_n) |-> !out_valid, "output valid during reset")

endmodule

bind simd_float_compare_mask sfcm_checker u_sfcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mask_bits (mask_bits)
);
